@@ src/cc20_pkg.sv @@
// shared types, constants and codes for the chacha20 block function
// no dependencies; used by the channel interfaces, the cell and the top level

package cc20_pkg;

    localparam int WORD_W = 32;
    localparam int REG_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W = 4;
    localparam int ROUND_PAIRS_DEF = 10;

    typedef logic [WORD_W-1:0] word_t;
    // one column of the state: [0] a row, [1] b row, [2] c row, [3] d row
    typedef logic [3:0][WORD_W-1:0] col_t;

    // "expand 32-byte k" constant words, word 0 at index 0
    localparam logic [3:0][WORD_W-1:0] SIGMA = {
        32'h6B206574, 32'h79622D32, 32'h3320646E, 32'h61707865
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0     = 3'd0,
        CFG_KEY1     = 3'd1,
        CFG_KEY2     = 3'd2,
        CFG_KEY3     = 3'd3,
        CFG_NONCE_LO = 3'd4,
        CFG_NONCE_HI = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DRAIN
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic load;   // take the initial column
        logic run;    // do one half quarter round
        logic half;   // second half: rotations by 8 and 7
        logic diag;   // current round works on diagonals
    } cell_ctrl_t;

endpackage

@@ src/cc20_channels.sv @@
// valid/ready channel interfaces for the chacha20 block function
// depends on cc20_pkg

interface cc20_ctr_if;
    logic                          valid;
    logic                          ready;
    logic [cc20_pkg::WORD_W-1:0]   block_counter;

    modport source (output valid, output block_counter, input ready);
    modport sink (input valid, input block_counter, output ready);
endinterface

interface cc20_ks_if;
    logic                          valid;
    logic                          ready;
    logic [cc20_pkg::WORD_W-1:0]   word_value;
    logic [cc20_pkg::IDX_W-1:0]    word_index;
    logic                          last_word;

    modport source (output valid, output word_value, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input word_value, input word_index, input last_word,
                  output ready);
endinterface

interface cc20_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cc20_pkg::CFG_IDX_W-1:0] index;
    logic [cc20_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/cc20_cell.sv @@
// one column cell: holds four state words and does half a quarter round a cycle while run is set
// depends on cc20_pkg; neighbors' results arrive for the diagonal shuffle

module cc20_cell
(
    input  logic                   clk,
    input  cc20_pkg::cell_ctrl_t   ctrl,
    input  cc20_pkg::col_t         init_col,
    input  cc20_pkg::col_t         nb_right,
    input  cc20_pkg::col_t         nb_opp,
    input  cc20_pkg::col_t         nb_left,
    output cc20_pkg::col_t         col,
    output cc20_pkg::col_t         new_col
);

    cc20_pkg::col_t col_reg;
    cc20_pkg::col_t col_next;
    cc20_pkg::word_t a1;
    cc20_pkg::word_t b1;
    cc20_pkg::word_t b2;
    cc20_pkg::word_t c1;
    cc20_pkg::word_t d1;
    cc20_pkg::word_t d2;

    // half quarter round
    always_comb
    begin
        a1 = col_reg[0] + col_reg[1];
        d1 = a1 ^ col_reg[3];
        d2 = ctrl.half ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
        c1 = col_reg[2] + d2;
        b1 = col_reg[1] ^ c1;
        b2 = ctrl.half ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    end

    assign new_col = {d2, c1, b2, a1};
    assign col = col_reg;

    always_comb
    begin
        col_next = col_reg;
        if (ctrl.load)
        begin
            col_next = init_col;
        end
        else if (ctrl.run)
        begin
            col_next = new_col;
            if (ctrl.half && !ctrl.diag)
            begin
                // column layout to diagonal layout
                col_next[1] = nb_right[1];
                col_next[2] = nb_opp[2];
                col_next[3] = nb_left[3];
            end
            else if (ctrl.half && ctrl.diag)
            begin
                // diagonal layout back to columns
                col_next[1] = nb_left[1];
                col_next[2] = nb_opp[2];
                col_next[3] = nb_right[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

endmodule

@@ src/chacha20_block_function.sv @@
// chacha20 block function top level: config registers, control, cell row, result register
// depends on cc20_pkg, cc20_channels (interfaces) and cc20_cell
//
//  channel | role  | payload                                  | direction
//  --------+-------+------------------------------------------+----------
//  ctr     | sink  | block_counter[31:0]                      | in
//  ks      | source| word_value[31:0], word_index[3:0], last  | out
//  cfg     | sink  | index[2:0], data[63:0]                   | in
//
// a counter beat is taken only while idle; the cells first load from the held
// counter, then run ROUND_PAIRS double rounds (ten at the default) as the
// four cells do half a quarter round each cycle
// sixteen keystream beats follow, one a cycle while ks.ready stays high; the next
// counter is taken only once the last beat has been loaded into the result register
// reset clears key and nonce to zero; a stalled ks beat holds and the drain waits
// cfg is always ready; writes to indexes six and seven are dropped

module chacha20_block_function
#(
    parameter int ROUND_PAIRS = cc20_pkg::ROUND_PAIRS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    cc20_ctr_if.sink    ctr,
    cc20_ks_if.source   ks,
    cc20_cfg_if.sink    cfg
);

    localparam int RND_W = (ROUND_PAIRS > 1) ? $clog2(ROUND_PAIRS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_PAIRS - 1);

    // configuration registers
    logic [3:0][cc20_pkg::REG_W-1:0] key_reg;
    logic [cc20_pkg::REG_W-1:0]      nonce_lo_reg;
    logic [cc20_pkg::WORD_W-1:0]     nonce_hi_reg;

    // control
    cc20_pkg::state_t           state_reg;
    cc20_pkg::state_t           state_next;
    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [RND_W-1:0]           rnd_reg;
    logic [RND_W-1:0]           rnd_next;
    logic [cc20_pkg::IDX_W-1:0] idx_reg;
    logic [cc20_pkg::IDX_W-1:0] idx_next;
    logic                       in_ready;
    logic                       ctr_fire;
    logic                       rounds_done;
    logic                       out_load;
    cc20_pkg::cell_ctrl_t       cell_ctrl;

    // block counter held for the final add
    logic [cc20_pkg::WORD_W-1:0] ctr_reg;

    // initial state and cell row
    logic [15:0][cc20_pkg::WORD_W-1:0] init_w;
    logic [3:0][3:0][cc20_pkg::WORD_W-1:0] cols;
    logic [3:0][3:0][cc20_pkg::WORD_W-1:0] new_cols;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [cc20_pkg::WORD_W-1:0] word_reg;
    logic [cc20_pkg::IDX_W-1:0]  index_reg;
    logic                        last_reg;

    // config writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cc20_pkg::CFG_KEY0:     key_reg[0]   <= cfg.data;
                cc20_pkg::CFG_KEY1:     key_reg[1]   <= cfg.data;
                cc20_pkg::CFG_KEY2:     key_reg[2]   <= cfg.data;
                cc20_pkg::CFG_KEY3:     key_reg[3]   <= cfg.data;
                cc20_pkg::CFG_NONCE_LO: nonce_lo_reg <= cfg.data;
                cc20_pkg::CFG_NONCE_HI: nonce_hi_reg <= cfg.data[cc20_pkg::WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // initial state: constants, key, counter, nonce
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_w[i] = cc20_pkg::SIGMA[i];
        end
        for (int k = 0; k < 8; k++)
        begin
            init_w[4 + k] = key_reg[k / 2][cc20_pkg::WORD_W * (k % 2) +: cc20_pkg::WORD_W];
        end
        init_w[12] = ctr_reg;
        init_w[13] = nonce_lo_reg[cc20_pkg::WORD_W-1:0];
        init_w[14] = nonce_lo_reg[cc20_pkg::REG_W-1:cc20_pkg::WORD_W];
        init_w[15] = nonce_hi_reg;
    end

    // counter is loaded on accept; the cells load from ctr_reg in the cycle after
    assign in_ready   = (state_reg == cc20_pkg::ST_IDLE);
    assign ctr.ready  = in_ready;
    assign ctr_fire   = ctr.valid && in_ready;
    assign rounds_done = (phase_reg == 2'd3) && (rnd_reg == RND_LAST);
    assign out_load   = (state_reg == cc20_pkg::ST_DRAIN) && (!out_valid_reg || ks.ready);

    always_ff @(posedge clk)
    begin
        if (ctr_fire)
        begin
            ctr_reg <= ctr.block_counter;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cc20_pkg::ST_IDLE:
            begin
                if (ctr_fire)
                begin
                    state_next = cc20_pkg::ST_ROUND;
                end
            end
            cc20_pkg::ST_ROUND:
            begin
                if (rounds_done)
                begin
                    state_next = cc20_pkg::ST_DRAIN;
                end
            end
            cc20_pkg::ST_DRAIN:
            begin
                if (out_load && (idx_reg == cc20_pkg::IDX_W'(15)))
                begin
                    state_next = cc20_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cc20_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine: cell control and counters
    always_comb
    begin
        cell_ctrl  = '0;
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        case (state_reg)
            cc20_pkg::ST_IDLE:
            begin
                phase_next = '0;
                rnd_next   = '0;
                idx_next   = '0;
            end
            cc20_pkg::ST_ROUND:
            begin
                // first round cycle loads the cells, rounds start next cycle
                cell_ctrl.load = (phase_reg == 2'd0) && (rnd_reg == '0) && !idx_reg[0];
                cell_ctrl.run  = !cell_ctrl.load;
                cell_ctrl.half = phase_reg[0];
                cell_ctrl.diag = phase_reg[1];
                if (cell_ctrl.load)
                begin
                    // idx bit 0 marks the load as done
                    idx_next = cc20_pkg::IDX_W'(1);
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                    if (rounds_done)
                    begin
                        idx_next = '0;
                    end
                end
            end
            cc20_pkg::ST_DRAIN:
            begin
                if (out_load)
                begin
                    idx_next = idx_reg + cc20_pkg::IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cc20_pkg::ST_IDLE;
            phase_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    // row of four column cells, wired in a ring for the diagonal shuffle
    for (genvar gi = 0; gi < 4; gi++)
    begin : g_cell
        cc20_cell u_cell
        (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .init_col ({init_w[12 + gi], init_w[8 + gi], init_w[4 + gi], init_w[gi]}),
            .nb_right (new_cols[(gi + 1) % 4]),
            .nb_opp   (new_cols[(gi + 2) % 4]),
            .nb_left  (new_cols[(gi + 3) % 4]),
            .col      (cols[gi]),
            .new_col  (new_cols[gi])
        );
    end

    // result register: word k sits in column k[1:0], row k[3:2]
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (ks.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            word_reg  <= cols[idx_reg[1:0]][idx_reg[3:2]] + init_w[idx_reg];
            index_reg <= idx_reg;
            last_reg  <= (idx_reg == cc20_pkg::IDX_W'(15));
        end
    end

    assign ks.valid      = out_valid_reg;
    assign ks.word_value = word_reg;
    assign ks.word_index = index_reg;
    assign ks.last_word  = last_reg;

`ifndef SYNTH
    // no beat is produced while rounds are running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cc20_pkg::ST_ROUND) |-> !out_load)
        else $error("result loaded during rounds");

    // drain always starts at word zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cc20_pkg::ST_DRAIN && $past(state_reg) == cc20_pkg::ST_ROUND)
        |-> (idx_reg == '0))
        else $error("drain did not start at word zero");

    // an accepted counter starts a fresh round sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        ctr_fire |=> (state_reg == cc20_pkg::ST_ROUND && phase_reg == '0
                      && rnd_reg == '0 && idx_reg == '0))
        else $error("round sequence not restarted on accept");

    // the last word of a block returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && idx_reg == cc20_pkg::IDX_W'(15)) |=> (state_reg == cc20_pkg::ST_IDLE))
        else $error("block did not finish after the last word");
`endif

endmodule
